@@ hw/rtl/rgbhsv_pkg.sv @@
package rgbhsv_pkg;

    localparam int CHAN_W   = 8;
    localparam int HUE_W    = 13;
    localparam int QUO_W    = 10;
    localparam int NUM_W    = CHAN_W + QUO_W;
    localparam int STEPS    = QUO_W;

    localparam logic [HUE_W-1:0] HUE_TURN     = 13'd5760;
    localparam logic [HUE_W-1:0] HUE_GREEN    = 13'd1920;
    localparam logic [HUE_W-1:0] HUE_BLUE     = 13'd3840;

    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0] rem;
        logic [QUO_W-1:0]  num_quo;
        logic [CHAN_W-1:0] div;
    } rgbhsv_lane_t;

    typedef struct packed {
        rgbhsv_lane_t      hue_lane;
        rgbhsv_lane_t      sat_lane;
        logic [1:0]        sector;
        logic              neg;
        logic              gray;
        logic [CHAN_W-1:0] bright;
    } rgbhsv_work_t;

    function automatic rgbhsv_lane_t div_step(input rgbhsv_lane_t lane);
        rgbhsv_lane_t      res;
        logic [CHAN_W:0]   trial;
        logic              q;
        trial = {lane.rem, lane.num_quo[QUO_W-1]};
        q     = (trial >= {1'b0, lane.div});
        res.div = lane.div;
        if (q)
        begin
            res.rem = CHAN_W'(trial - {1'b0, lane.div});
        end
        else
        begin
            res.rem = trial[CHAN_W-1:0];
        end
        res.num_quo = {lane.num_quo[QUO_W-2:0], q};
        return res;
    endfunction

endpackage

@@ hw/rtl/rgbhsv_front.sv @@
module rgbhsv_front
    import rgbhsv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    input  logic [CHAN_W-1:0] red,
    input  logic [CHAN_W-1:0] green,
    input  logic [CHAN_W-1:0] blue,
    output logic              up_take,
    output logic              down_valid,
    output rgbhsv_work_t      down_work,
    input  logic              down_take
);

    logic              valid_reg;
    rgbhsv_work_t      work_reg;
    rgbhsv_work_t      work_next;
    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] mn;
    logic [CHAN_W-1:0] chroma;
    logic [CHAN_W-1:0] pos;
    logic [CHAN_W-1:0] negv;
    logic [CHAN_W-1:0] diff;
    logic [1:0]        sector;
    logic [NUM_W-1:0]  num_hue;
    logic [NUM_W-1:0]  num_sat;

    always_comb
    begin
        if (red >= green && red >= blue)
        begin
            sector = SECT_RED;
            mx     = red;
            pos    = green;
            negv   = blue;
        end
        else if (green >= blue)
        begin
            sector = SECT_GREEN;
            mx     = green;
            pos    = blue;
            negv   = red;
        end
        else
        begin
            sector = SECT_BLUE;
            mx     = blue;
            pos    = red;
            negv   = green;
        end
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        chroma  = mx - mn;
        diff    = (pos >= negv) ? (pos - negv) : (negv - pos);
        num_hue = {diff, 10'd0} - {4'd0, diff, 6'd0};
        num_sat = {2'd0, chroma, 8'd0} - {10'd0, chroma};

        work_next.hue_lane.rem     = num_hue[NUM_W-1:QUO_W];
        work_next.hue_lane.num_quo = num_hue[QUO_W-1:0];
        work_next.hue_lane.div     = chroma;
        work_next.sat_lane.rem     = num_sat[NUM_W-1:QUO_W];
        work_next.sat_lane.num_quo = num_sat[QUO_W-1:0];
        work_next.sat_lane.div     = mx;
        work_next.sector           = sector;
        work_next.neg              = (pos < negv);
        work_next.gray             = (chroma == '0);
        work_next.bright           = mx;
    end

    assign up_take    = !valid_reg || down_take;
    assign down_valid = valid_reg;
    assign down_work  = work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_take)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_take && up_valid)
        begin
            work_reg <= work_next;
        end
    end

endmodule

@@ hw/rtl/rgbhsv_div_cell.sv @@
module rgbhsv_div_cell
    import rgbhsv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    input  rgbhsv_work_t up_work,
    output logic         up_take,
    output logic         down_valid,
    output rgbhsv_work_t down_work,
    input  logic         down_take
);

    logic         valid_reg;
    rgbhsv_work_t work_reg;
    rgbhsv_work_t work_next;

    always_comb
    begin
        work_next          = up_work;
        work_next.hue_lane = div_step(up_work.hue_lane);
        work_next.sat_lane = div_step(up_work.sat_lane);
    end

    assign up_take    = !valid_reg || down_take;
    assign down_valid = valid_reg;
    assign down_work  = work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_take)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_take && up_valid)
        begin
            work_reg <= work_next;
        end
    end

endmodule

@@ hw/rtl/rgbhsv_back.sv @@
module rgbhsv_back
    import rgbhsv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    input  rgbhsv_work_t      up_work,
    output logic              up_take,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [HUE_W-1:0]  hue,
    output logic [CHAN_W-1:0] saturation,
    output logic [CHAN_W-1:0] brightness,
    output logic              is_gray
);

    logic              valid_reg;
    logic [HUE_W-1:0]  hue_reg;
    logic [HUE_W-1:0]  hue_next;
    logic [CHAN_W-1:0] sat_reg;
    logic [CHAN_W-1:0] sat_next;
    logic [CHAN_W-1:0] bright_reg;
    logic              gray_reg;
    logic [HUE_W-1:0]  mag;
    logic [HUE_W-1:0]  offset;

    always_comb
    begin
        mag = HUE_W'(up_work.hue_lane.num_quo);
        case (up_work.sector)
            SECT_GREEN: offset = HUE_GREEN;
            SECT_BLUE:  offset = HUE_BLUE;
            default:    offset = '0;
        endcase
        if (up_work.gray)
        begin
            hue_next = '0;
        end
        else if (!up_work.neg)
        begin
            hue_next = offset + mag;
        end
        else if (offset < mag)
        begin
            hue_next = offset + HUE_TURN - mag;
        end
        else
        begin
            hue_next = offset - mag;
        end
        sat_next = (up_work.bright == '0) ? '0 : up_work.sat_lane.num_quo[CHAN_W-1:0];
    end

    assign up_take    = !valid_reg || !out_stall;
    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;
    assign is_gray    = gray_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_take)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_take && up_valid)
        begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= up_work.bright;
            gray_reg   <= up_work.gray;
        end
    end

endmodule

@@ hw/rtl/rgb_to_hsv_converter.sv @@
// Stages from an accepted item to its result: 1 min/max stage,
// 10 divider cells, 1 output register.
// One item per cycle unless stalled; each divider cell retires a quotient bit.
// Stall from the output ripples back only through full stages; bubbles close.
// Reset: rst_n asynchronous, active low; clears all stage valid bits.
module rgb_to_hsv_converter
    import rgbhsv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CHAN_W-1:0] red,
    input  logic [CHAN_W-1:0] green,
    input  logic [CHAN_W-1:0] blue,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [HUE_W-1:0]  hue,
    output logic [CHAN_W-1:0] saturation,
    output logic [CHAN_W-1:0] brightness,
    output logic              is_gray
);

    logic         stage_valid [STEPS+1];
    logic         stage_take  [STEPS+1];
    rgbhsv_work_t stage_work  [STEPS+1];
    logic         front_take;

    rgbhsv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (in_valid),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .up_take    (front_take),
        .down_valid (stage_valid[0]),
        .down_work  (stage_work[0]),
        .down_take  (stage_take[0])
    );

    assign in_stall = !front_take;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        rgbhsv_div_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (stage_valid[i]),
            .up_work    (stage_work[i]),
            .up_take    (stage_take[i]),
            .down_valid (stage_valid[i+1]),
            .down_work  (stage_work[i+1]),
            .down_take  (stage_take[i+1])
        );
    end

    rgbhsv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (stage_valid[STEPS]),
        .up_work    (stage_work[STEPS]),
        .up_take    (stage_take[STEPS]),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .is_gray    (is_gray)
    );

    a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_gray |-> hue == '0 && saturation == '0)
        else $error("gray item with nonzero hue or saturation");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hue < HUE_TURN)
        else $error("hue out of range");

    a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && brightness == '0 |-> saturation == '0 && is_gray)
        else $error("black item with nonzero saturation");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled item dropped");

endmodule
